// File: design/ssfb_pkg.sv
// ----------------------------------------------------------------------------
// ssfb_pkg
// Shared types, constants and arithmetic helpers of the slit-scan frame blend.
// ----------------------------------------------------------------------------
`default_nettype none
package ssfb_pkg;

   localparam int FRAME_DEPTH_DEF  = 32;
   localparam int IMAGE_WIDTH_DEF  = 320;
   localparam int IMAGE_HEIGHT_DEF = 240;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 1'b1;

   // root pipeline: 32-bit radicand, two result bits per stage
   localparam int ROOT_W   = 16;
   localparam int REM_W    = 18;
   localparam int ROOT_NST = 8;

   typedef struct packed {
      logic [8:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [8:0] out_x;
      logic [7:0] out_y;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_type;

   // per-pixel information carried alongside the arithmetic
   typedef struct packed {
      logic [8:0]  x;
      logic [7:0]  y;
      logic [23:0] rgb;
      logic        frame_start;
      logic        in_range;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_res_type;

   // history read result handed to the blend stage
   typedef struct packed {
      side_type    side;
      logic [6:0]  w1;
      logic        near_live;
      logic        far_live;
      logic [23:0] near_rgb;
      logic [23:0] far_rgb;
   } hist_out_type;

   function automatic sqrt_res_type sqrt_step(input logic [REM_W-1:0] rem,
                                              input logic [ROOT_W-1:0] root,
                                              input logic [1:0] pair);
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      sqrt_res_type     r;
      acc   = {rem, pair};
      trial = {2'b00, root, 2'b01};
      if (acc >= trial) begin
         r.rem  = REM_W'(acc - trial);
         r.root = {root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = acc[REM_W-1:0];
         r.root = {root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] blend_chan(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] w0, input logic [6:0] w1);
      logic [15:0] p0;
      logic [15:0] p1;
      logic [9:0]  s;
      p0 = c0 * w0;
      p1 = c1 * {1'b0, w1};
      s  = 10'(p0[15:7]) + 10'(p1[15:7]);
      return (s > 10'd255) ? 8'hFF : s[7:0];
   endfunction

endpackage
`default_nettype wire

// File: design/ssfb_sqrt.sv
// ----------------------------------------------------------------------------
// ssfb_sqrt
// Pipelined integer square root of a 32-bit radicand, two bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ssfb_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [31:0]                     in_rad,
   input  wire ssfb_pkg::side_type              in_side,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic [ssfb_pkg::ROOT_W-1:0]          out_root,
   output ssfb_pkg::side_type                   out_side
);

   localparam int NS = ssfb_pkg::ROOT_NST;

   logic [NS-1:0]                 vld_ff;
   logic [NS:0]                   adv;
   logic [31:0]                   rad_ff  [NS];
   logic [ssfb_pkg::REM_W-1:0]    rem_ff  [NS];
   logic [ssfb_pkg::ROOT_W-1:0]   root_ff [NS];
   ssfb_pkg::side_type            side_ff [NS];

   assign adv[NS]   = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                         vld_in;
      logic [31:0]                  rad_in;
      logic [ssfb_pkg::REM_W-1:0]   rem_src;
      logic [ssfb_pkg::ROOT_W-1:0]  root_src;
      ssfb_pkg::side_type           side_in;
      ssfb_pkg::sqrt_res_type       r_a;
      ssfb_pkg::sqrt_res_type       r_b;

      assign adv[s] = !vld_ff[s] || adv[s+1];

      if (s == 0) begin : g_first
         assign vld_in   = in_valid;
         assign rad_in   = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_in  = in_side;
      end else begin : g_next
         assign vld_in   = vld_ff[s-1];
         assign rad_in   = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_in  = side_ff[s-1];
      end

      always_comb begin
         r_a = ssfb_pkg::sqrt_step(rem_src, root_src, rad_in[31-4*s -: 2]);
         r_b = ssfb_pkg::sqrt_step(r_a.rem, r_a.root, rad_in[29-4*s -: 2]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            vld_ff[s] <= vld_in;
         end
         if (adv[s]) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= r_b.rem;
            root_ff[s] <= r_b.root;
            side_ff[s] <= side_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: design/ssfb_hist.sv
// ----------------------------------------------------------------------------
// ssfb_hist
// Frame history ring: slot bookkeeping, pixel write and two-frame read.
// ----------------------------------------------------------------------------
`default_nettype none
module ssfb_hist #(
   parameter int FRAME_DEPTH  = ssfb_pkg::FRAME_DEPTH_DEF,
   parameter int IMAGE_WIDTH  = ssfb_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = ssfb_pkg::IMAGE_HEIGHT_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [ssfb_pkg::ROOT_W-1:0] in_dist,
   input  wire ssfb_pkg::side_type         in_side,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output ssfb_pkg::hist_out_type          out_data
);

   localparam int SW    = $clog2(FRAME_DEPTH);
   localparam int CW    = $clog2(FRAME_DEPTH + 1);
   localparam int PIX   = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int PW    = $clog2(PIX);
   localparam int DEPTH = FRAME_DEPTH * PIX;
   localparam int AW    = $clog2(DEPTH);

   logic [23:0] hist_mem [DEPTH];

   // stage 0: pixel offset
   logic                          v0_ff;
   ssfb_pkg::side_type            side0_ff;
   logic [ssfb_pkg::ROOT_W-1:0]   dist0_ff;
   logic [PW-1:0]                 off0_ff;
   logic [PW-1:0]                 off0_in;

   // stage 1: memory access
   logic                          v1_ff;
   ssfb_pkg::side_type            side1_ff;
   logic [6:0]                    w1_ff;
   logic                          near_live_ff;
   logic                          far_live_ff;
   logic [23:0]                   near_ff;
   logic [23:0]                   far_ff;

   logic [SW-1:0] newest_ff;
   logic [SW-1:0] newest_in;
   logic [CW-1:0] stored_ff;
   logic [CW-1:0] stored_in;

   logic          adv0;
   logic          adv1;
   logic          take1;
   logic [CW-1:0] lim;
   logic [8:0]    i0;
   logic [9:0]    i1;
   logic [SW-1:0] k0;
   logic [SW-1:0] k1;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;

   function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot,
                                               input logic [PW-1:0] off);
      return AW'(32'(slot) * PIX + 32'(off));
   endfunction

   function automatic logic [SW-1:0] back_slot(input logic [SW-1:0] newest,
                                               input logic [SW-1:0] k);
      if (newest >= k) begin
         return SW'(newest - k);
      end
      return SW'(32'(newest) + FRAME_DEPTH - 32'(k));
   endfunction

   assign adv1     = !v1_ff || out_ready;
   assign adv0     = !v0_ff || adv1;
   assign in_ready = adv0;
   assign take1    = adv1 && v0_ff;

   assign off0_in = in_side.in_range ?
                    PW'(32'(in_side.y) * IMAGE_WIDTH + 32'(in_side.x)) : '0;

   always_comb begin
      newest_in = newest_ff;
      stored_in = stored_ff;
      if (side0_ff.frame_start) begin
         newest_in = (newest_ff == SW'(FRAME_DEPTH - 1)) ? '0 : SW'(newest_ff + 1'b1);
         if (32'(stored_ff) < FRAME_DEPTH) begin
            stored_in = CW'(stored_ff + 1'b1);
         end
      end
      // no frame begun yet counts as one frame
      lim = (stored_in == '0) ? '0 : CW'(stored_in - 1'b1);
      i0  = dist0_ff[15:7];
      i1  = 10'(i0) + 10'd1;
      k0  = (i0 > 9'(lim)) ? SW'(lim) : SW'(i0);
      k1  = (i1 > 10'(lim)) ? SW'(lim) : SW'(i1);
      wr_addr  = slot_addr(newest_in, off0_ff);
      rd0_addr = slot_addr(back_slot(newest_in, k0), off0_ff);
      rd1_addr = slot_addr(back_slot(newest_in, k1), off0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         newest_ff <= '0;
         stored_ff <= '0;
      end else begin
         if (adv0) begin
            v0_ff <= in_valid;
         end
         if (adv1) begin
            v1_ff <= v0_ff;
         end
         if (take1) begin
            newest_ff <= newest_in;
            stored_ff <= stored_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         side0_ff <= in_side;
         dist0_ff <= in_dist;
         off0_ff  <= off0_in;
      end
      if (adv1) begin
         side1_ff     <= side0_ff;
         w1_ff        <= dist0_ff[6:0];
         near_live_ff <= (k0 == '0);
         far_live_ff  <= (k1 == '0);
      end
   end

   // a read of the slot being written is flagged live and replaced by the input pixel in the blend, so no bypass
   always_ff @(posedge clock) begin
      if (take1 && side0_ff.in_range) begin
         hist_mem[wr_addr] <= side0_ff.rgb;
      end
      if (adv1) begin
         near_ff <= hist_mem[rd0_addr];
         far_ff  <= hist_mem[rd1_addr];
      end
   end

   assign out_valid          = v1_ff;
   assign out_data.side      = side1_ff;
   assign out_data.w1        = w1_ff;
   assign out_data.near_live = near_live_ff;
   assign out_data.far_live  = far_live_ff;
   assign out_data.near_rgb  = near_ff;
   assign out_data.far_rgb   = far_ff;

endmodule
`default_nettype wire

// File: design/ssfb_blend.sv
// ----------------------------------------------------------------------------
// ssfb_blend
// Weighted mix of two history frames per channel, into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ssfb_blend (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire ssfb_pkg::hist_out_type in_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ssfb_pkg::rsp_type           rsp_data
);

   logic              vld_ff;
   ssfb_pkg::rsp_type rsp_ff;
   ssfb_pkg::rsp_type rsp_in;
   logic [23:0]       c0;
   logic [23:0]       c1;
   logic [7:0]        w0;

   assign in_ready = !vld_ff || rsp_ready;

   always_comb begin
      c0 = in_data.near_live ? in_data.side.rgb : in_data.near_rgb;
      c1 = in_data.far_live  ? in_data.side.rgb : in_data.far_rgb;
      w0 = 8'd128 - 8'(in_data.w1);
      rsp_in.out_x = in_data.side.x;
      rsp_in.out_y = in_data.side.y;
      if (in_data.side.in_range) begin
         rsp_in.out_red   = ssfb_pkg::blend_chan(c0[23:16], c1[23:16], w0, in_data.w1);
         rsp_in.out_green = ssfb_pkg::blend_chan(c0[15:8], c1[15:8], w0, in_data.w1);
         rsp_in.out_blue  = ssfb_pkg::blend_chan(c0[7:0], c1[7:0], w0, in_data.w1);
      end else begin
         // off-image pixel: pass the colour through
         rsp_in.out_red   = in_data.side.rgb[23:16];
         rsp_in.out_green = in_data.side.rgb[15:8];
         rsp_in.out_blue  = in_data.side.rgb[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
      if (in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: design/slit_scan_frame_blend_top.sv
// ----------------------------------------------------------------------------
// slit_scan_frame_blend_top
// Slit-scan time displacement: blends two history frames by centre distance.
// ----------------------------------------------------------------------------
// One pixel transfer is taken every clock while results keep flowing; each
// pixel's result is offered once it has passed the 13 register stages, which
// are the two distance stages, the eight-stage square-root pipeline, the
// offset stage, the history memory read and the blend register. Every stage
// holds its own item, so a stalled result only stops the stages behind it
// once they fill. The history memory (FRAME_DEPTH x IMAGE_WIDTH x
// IMAGE_HEIGHT words) is not cleared.
`default_nettype none
module slit_scan_frame_blend_top #(
   parameter int FRAME_DEPTH  = ssfb_pkg::FRAME_DEPTH_DEF,
   parameter int IMAGE_WIDTH  = ssfb_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = ssfb_pkg::IMAGE_HEIGHT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire ssfb_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output ssfb_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [ssfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssfb_pkg::CSR_DAT_W-1:0]  csr_data
);

   logic [10:0] center_x_ff;
   logic [9:0]  center_y_ff;

   logic               v0_ff;
   ssfb_pkg::side_type side0_ff;
   ssfb_pkg::side_type side0_in;
   logic signed [11:0] dx_ff;
   logic signed [10:0] dy_ff;

   logic               v1_ff;
   ssfb_pkg::side_type side1_ff;
   logic [23:0]        d2_ff;
   logic [23:0]        d2_in;

   logic adv0;
   logic adv1;
   logic sq_in_ready;
   logic sq_valid;
   logic [ssfb_pkg::ROOT_W-1:0] sq_root;
   ssfb_pkg::side_type          sq_side;
   logic hs_in_ready;
   logic hs_valid;
   ssfb_pkg::hist_out_type hs_data;
   logic bl_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ssfb_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            ssfb_pkg::CSR_CENTER_Y: center_y_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign adv1      = !v1_ff || sq_in_ready;
   assign adv0      = !v0_ff || adv1;
   assign req_ready = adv0;

   always_comb begin
      side0_in.x           = req_data.pixel_x;
      side0_in.y           = req_data.pixel_y;
      side0_in.rgb         = {req_data.in_red, req_data.in_green, req_data.in_blue};
      side0_in.frame_start = req_data.frame_start;
      side0_in.in_range    = (32'(req_data.pixel_x) < IMAGE_WIDTH) &&
                             (32'(req_data.pixel_y) < IMAGE_HEIGHT);
      d2_in = 24'(dx_ff * dx_ff) + 24'(dy_ff * dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         if (adv0) begin
            v0_ff <= req_valid;
         end
         if (adv1) begin
            v1_ff <= v0_ff;
         end
      end
      if (adv0) begin
         side0_ff <= side0_in;
         dx_ff    <= signed'({3'b000, req_data.pixel_x}) - signed'({1'b0, center_x_ff});
         dy_ff    <= signed'({3'b000, req_data.pixel_y}) - signed'({1'b0, center_y_ff});
      end
      if (adv1) begin
         side1_ff <= side0_ff;
         d2_ff    <= d2_in;
      end
   end

   ssfb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (sq_in_ready),
      .in_rad    ({d2_ff, 8'h00}),
      .in_side   (side1_ff),
      .out_valid (sq_valid),
      .out_ready (hs_in_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   ssfb_hist #(
      .FRAME_DEPTH  (FRAME_DEPTH),
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (hs_in_ready),
      .in_dist   (sq_root),
      .in_side   (sq_side),
      .out_valid (hs_valid),
      .out_ready (bl_in_ready),
      .out_data  (hs_data)
   );

   ssfb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hs_valid),
      .in_ready  (bl_in_ready),
      .in_data   (hs_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // an empty result register lets the whole pipe advance
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_no_result_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result present straight after reset");

endmodule
`default_nettype wire
